FILE: sv/msgc_pkg.sv
// Shared types, constants and helpers for the multicast sequence gap checker.
// No dependencies; every other file in this folder imports it.
package msgc_pkg;

    localparam int NUM_STREAMS        = 4;
    localparam int SENDERS_PER_STREAM = 16;
    localparam int MAX_FRAME_BYTES    = 2048;
    localparam int TABLE_SIZE         = NUM_STREAMS * SENDERS_PER_STREAM;

    localparam int SENDER_W = (SENDERS_PER_STREAM > 1) ? $clog2(SENDERS_PER_STREAM) : 1;
    localparam int TABLE_W  = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int POS_W    = $clog2(MAX_FRAME_BYTES + 1);
    localparam int OFF_W    = ((POS_W > 11) ? POS_W : 11) + 2;
    localparam int STREAM_W = 2;

    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int MATCH_W   = 49;
    localparam int LAYOUT_W  = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [15:0] ETHERTYPE_VLAN = 16'h8100;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [7:0]  PROTO_GRE      = 8'd47;
    localparam logic [3:0]  IP_VERSION4    = 4'd4;
    localparam logic [3:0]  IHL_MIN        = 4'd5;
    localparam int          ETH_TYPE_POS   = 12;
    localparam int          GRE_BIT_C      = 7;
    localparam int          GRE_BIT_K      = 5;
    localparam int          GRE_BIT_S      = 4;

    typedef enum logic [3:0] {
        ST_TRUNC    = 4'd0,
        ST_NOT_IPV4 = 4'd1,
        ST_NOT_L4   = 4'd2,
        ST_UNKNOWN  = 4'd3,
        ST_SHORT    = 4'd4,
        ST_FIRST    = 4'd5,
        ST_IN_ORDER = 4'd6,
        ST_GAP      = 4'd7,
        ST_FULL     = 4'd8
    } status_t;

    typedef enum logic [2:0] {
        PH_ETH,
        PH_IP,
        PH_GRE,
        PH_INNER,
        PH_UDP,
        PH_PAYLOAD,
        PH_DONE
    } parse_phase_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_CMP,
        BK_OUT
    } tbl_state_t;

    // one judged frame on its way from the parser to the sender table
    typedef struct packed {
        logic                lookup;
        status_t             status;
        logic [STREAM_W-1:0] stream;
        logic [63:0]         sender;
        logic [63:0]         seq;
    } job_t;

    function automatic logic [3:0] field_size(input logic [3:0] code);
        logic [3:0] sz;
        case (code)
            4'd1, 4'd2, 4'd4, 4'd8: sz = code;
            default:                sz = 4'd0;
        endcase
        return sz;
    endfunction

endpackage

FILE: sv/msgc_front.sv
// Byte-wise frame parser: walks Ethernet, VLAN, IPv4, GRE and UDP headers,
// matches the stream and captures the payload fields. Depends on msgc_pkg.
module msgc_front
    import msgc_pkg::*;
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               take_word,
    input  logic [7:0]                         in_byte,
    input  logic                               in_last,
    input  logic                               in_mismatch,
    input  logic [NUM_STREAMS-1:0][MATCH_W-1:0]  match_cfg,
    input  logic [NUM_STREAMS-1:0][LAYOUT_W-1:0] layout_cfg,
    output logic                               push,
    output job_t                               job
);

    logic [POS_W-1:0]    pos_reg, pos_next;
    parse_phase_t        phase_reg, phase_next;
    logic [OFF_W-1:0]    mark_reg, mark_next;
    logic [39:0]         hist_reg, hist_next;
    logic [7:0]          vihl_reg, vihl_next;
    logic [7:0]          proto_reg, proto_next;
    logic [31:0]         addr_reg, addr_next;
    logic [STREAM_W-1:0] stream_reg, stream_next;
    status_t             verdict_reg, verdict_next;
    logic [OFF_W-1:0]    qs_reg, qs_next, qe_reg, qe_next;
    logic [OFF_W-1:0]    ss_reg, ss_next, se_reg, se_next;
    logic [OFF_W-1:0]    end_reg, end_next;
    logic                qswap_reg, qswap_next, sswap_reg, sswap_next;
    logic [63:0]         seq_reg, seq_next, snd_reg, snd_next;

    logic             stored;
    logic             frame_end;
    logic [OFF_W-1:0] p;
    logic [15:0]      eth_type;
    logic [15:0]      ulen, plen;
    logic [47:0]      dest;
    logic             found;
    logic [STREAM_W-1:0] found_idx;
    logic [LAYOUT_W-1:0] lay;
    logic [3:0]       qsz, ssz;
    logic [OFF_W-1:0] ps, qs_w, qe_w, ss_w, se_w;
    logic [OFF_W-1:0] qdiff, sdiff;
    logic [OFF_W-1:0] n_bytes;

    assign stored    = take_word && (pos_reg < POS_W'(MAX_FRAME_BYTES));
    assign frame_end = take_word && in_last;
    assign p         = OFF_W'(pos_reg);
    assign qdiff     = p - qs_reg;
    assign sdiff     = p - ss_reg;

    // header walk
    always_comb
    begin
        pos_next     = pos_reg;
        phase_next   = phase_reg;
        mark_next    = mark_reg;
        hist_next    = hist_reg;
        vihl_next    = vihl_reg;
        proto_next   = proto_reg;
        addr_next    = addr_reg;
        stream_next  = stream_reg;
        verdict_next = verdict_reg;
        qs_next      = qs_reg;
        qe_next      = qe_reg;
        ss_next      = ss_reg;
        se_next      = se_reg;
        end_next     = end_reg;
        qswap_next   = qswap_reg;
        sswap_next   = sswap_reg;
        seq_next     = seq_reg;
        snd_next     = snd_reg;
        eth_type     = {hist_reg[7:0], in_byte};
        ulen         = hist_reg[23:8];
        plen         = (ulen >= 16'd8) ? (ulen - 16'd8) : 16'd0;
        dest         = {addr_reg, hist_reg[39:24]};
        found        = 1'b0;
        found_idx    = '0;
        for (int s = 0; s < NUM_STREAMS; s++)
        begin
            if (!found && match_cfg[s][48] && (match_cfg[s][47:0] == dest))
            begin
                found     = 1'b1;
                found_idx = STREAM_W'(s);
            end
        end
        lay  = layout_cfg[found_idx];
        qsz  = field_size(lay[14:11]);
        ssz  = field_size(lay[30:27]);
        ps   = mark_reg + OFF_W'(8);
        qs_w = ps + OFF_W'(lay[10:0]);
        qe_w = qs_w + OFF_W'(qsz);
        ss_w = ps + OFF_W'(lay[26:16]);
        se_w = ss_w + OFF_W'(ssz);

        if (stored)
        begin
            pos_next  = pos_reg + 1'b1;
            hist_next = {hist_reg[31:0], in_byte};
            case (phase_reg)
                PH_ETH:
                begin
                    if (p == mark_reg + OFF_W'(1))
                    begin
                        if (eth_type == ETHERTYPE_VLAN)
                            mark_next = mark_reg + OFF_W'(4);
                        else if (eth_type == ETHERTYPE_IPV4)
                        begin
                            mark_next  = mark_reg + OFF_W'(2);
                            phase_next = PH_IP;
                        end
                        else
                        begin
                            verdict_next = ST_NOT_IPV4;
                            phase_next   = PH_DONE;
                        end
                    end
                end
                PH_IP, PH_INNER:
                begin
                    if (p == mark_reg)
                        vihl_next = in_byte;
                    if (p == mark_reg + OFF_W'(9))
                        proto_next = in_byte;
                    if (p == mark_reg + OFF_W'(19))
                    begin
                        addr_next = {hist_reg[23:0], in_byte};
                        mark_next = mark_reg + OFF_W'({vihl_reg[3:0], 2'b00});
                        if ((phase_reg == PH_IP && vihl_reg[7:4] != IP_VERSION4)
                            || vihl_reg[3:0] < IHL_MIN)
                        begin
                            verdict_next = ST_NOT_IPV4;
                            phase_next   = PH_DONE;
                        end
                        else if (phase_reg == PH_INNER || proto_reg == PROTO_UDP)
                            phase_next = PH_UDP;
                        else if (proto_reg == PROTO_GRE)
                            phase_next = PH_GRE;
                        else
                        begin
                            verdict_next = ST_NOT_L4;
                            phase_next   = PH_DONE;
                        end
                    end
                end
                PH_GRE:
                begin
                    // base word, then one word for each of C, K and S
                    if (p == mark_reg + OFF_W'(3))
                    begin
                        mark_next  = mark_reg + OFF_W'(4)
                                   + OFF_W'({hist_reg[16 + GRE_BIT_C], 2'b00})
                                   + OFF_W'({hist_reg[16 + GRE_BIT_K], 2'b00})
                                   + OFF_W'({hist_reg[16 + GRE_BIT_S], 2'b00});
                        phase_next = PH_INNER;
                    end
                end
                PH_UDP:
                begin
                    if (p == mark_reg + OFF_W'(7))
                    begin
                        if (!found)
                        begin
                            verdict_next = ST_UNKNOWN;
                            phase_next   = PH_DONE;
                        end
                        else
                        begin
                            stream_next = found_idx;
                            if ((16'(lay[10:0]) + 16'(qsz) > plen)
                                || (16'(lay[26:16]) + 16'(ssz) > plen))
                            begin
                                verdict_next = ST_SHORT;
                                phase_next   = PH_DONE;
                            end
                            else
                            begin
                                qs_next    = qs_w;
                                qe_next    = qe_w;
                                ss_next    = ss_w;
                                se_next    = se_w;
                                qswap_next = lay[15];
                                sswap_next = lay[31];
                                end_next   = (qe_w > se_w) ? qe_w : se_w;
                                phase_next = PH_PAYLOAD;
                            end
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    if (p >= qs_reg && p < qe_reg)
                        seq_next = qswap_reg ? {seq_reg[55:0], in_byte}
                                 : (seq_reg | (64'(in_byte) << {qdiff[2:0], 3'b000}));
                    if (p >= ss_reg && p < se_reg)
                        snd_next = sswap_reg ? {snd_reg[55:0], in_byte}
                                 : (snd_reg | (64'(in_byte) << {sdiff[2:0], 3'b000}));
                end
                default:
                begin
                end
            endcase
        end
    end

    // verdict for the frame on its last word
    always_comb
    begin
        n_bytes    = OFF_W'(pos_next);
        push       = frame_end;
        job.lookup = 1'b0;
        job.status = ST_TRUNC;
        job.stream = stream_next;
        job.sender = snd_next;
        job.seq    = seq_next;
        if (in_mismatch)
            job.stream = '0;
        else if (phase_next == PH_DONE)
            job.status = verdict_next;
        else if (phase_next == PH_PAYLOAD && end_next <= n_bytes)
        begin
            job.lookup = 1'b1;
            job.status = ST_FIRST;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            phase_reg   <= PH_ETH;
            mark_reg    <= OFF_W'(ETH_TYPE_POS);
            stream_reg  <= '0;
            verdict_reg <= ST_TRUNC;
            seq_reg     <= '0;
            snd_reg     <= '0;
        end
        else if (frame_end)
        begin
            pos_reg     <= '0;
            phase_reg   <= PH_ETH;
            mark_reg    <= OFF_W'(ETH_TYPE_POS);
            stream_reg  <= '0;
            verdict_reg <= ST_TRUNC;
            seq_reg     <= '0;
            snd_reg     <= '0;
        end
        else
        begin
            pos_reg     <= pos_next;
            phase_reg   <= phase_next;
            mark_reg    <= mark_next;
            stream_reg  <= stream_next;
            verdict_reg <= verdict_next;
            seq_reg     <= seq_next;
            snd_reg     <= snd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hist_reg  <= hist_next;
        vihl_reg  <= vihl_next;
        proto_reg <= proto_next;
        addr_reg  <= addr_next;
        qs_reg    <= qs_next;
        qe_reg    <= qe_next;
        ss_reg    <= ss_next;
        se_reg    <= se_next;
        end_reg   <= end_next;
        qswap_reg <= qswap_next;
        sswap_reg <= sswap_next;
    end

endmodule

FILE: sv/msgc_queue.sv
// Short job queue between the frame parser and the sender table.
// Depends on msgc_pkg for the job type and depth.
module msgc_queue
    import msgc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic full,
    output logic empty
);

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;

    assign full  = (cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop  ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_job;
    end

endmodule

FILE: sv/msgc_table.sv
// Sender table: per stream and sender, the last sequence seen; scans a
// stream's entries one by one and drives the result register. Uses msgc_pkg.
module msgc_table
    import msgc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_empty,
    input  job_t         head,
    output logic         pop,
    output logic         res_valid,
    input  logic         res_ready,
    output logic [199:0] res_data
);

    tbl_state_t        state_reg, state_next;
    job_t              job_reg, job_next;
    logic [SENDER_W-1:0] idx_reg, idx_next;
    logic [TABLE_W-1:0] addr_reg, addr_next;
    logic              free_found_reg, free_found_next;
    logic [TABLE_W-1:0] free_addr_reg, free_addr_next;
    logic [TABLE_SIZE-1:0] valid_reg, valid_next;
    status_t           res_status_reg, res_status_next;
    logic [63:0]       res_expect_reg, res_expect_next;

    logic [63:0]       tag_mem [TABLE_SIZE];
    logic [63:0]       seq_mem [TABLE_SIZE];
    logic [63:0]       tag_q, last_q;

    logic              rd_en, tag_we, seq_we;
    logic [TABLE_W-1:0] rd_addr, wr_addr;
    logic [TABLE_W+STREAM_W-1:0] base_w;
    logic              hit, last_entry, free_now;
    logic [63:0]       expect_w;
    logic [63:0]       out_sender, out_seq;

    assign base_w     = (TABLE_W+STREAM_W)'(job_reg.stream)
                      * (TABLE_W+STREAM_W)'(SENDERS_PER_STREAM);
    assign hit        = valid_reg[addr_reg] && (tag_q == job_reg.sender);
    assign last_entry = (idx_reg == SENDER_W'(SENDERS_PER_STREAM - 1));
    assign free_now   = free_found_reg || !valid_reg[addr_reg];
    assign expect_w   = last_q + 64'd1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
                if (!q_empty)
                    state_next = head.lookup ? BK_READ : BK_OUT;
            BK_READ:
                state_next = BK_CMP;
            BK_CMP:
                if (hit || last_entry)
                    state_next = BK_OUT;
                else
                    state_next = BK_READ;
            BK_OUT:
                if (res_ready)
                    state_next = BK_IDLE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop             = 1'b0;
        job_next        = job_reg;
        idx_next        = idx_reg;
        addr_next       = addr_reg;
        free_found_next = free_found_reg;
        free_addr_next  = free_addr_reg;
        valid_next      = valid_reg;
        res_status_next = res_status_reg;
        res_expect_next = res_expect_reg;
        rd_en           = 1'b0;
        rd_addr         = TABLE_W'(base_w + (TABLE_W+STREAM_W)'(idx_reg));
        tag_we          = 1'b0;
        seq_we          = 1'b0;
        wr_addr         = addr_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop             = 1'b1;
                    job_next        = head;
                    idx_next        = '0;
                    free_found_next = 1'b0;
                    res_status_next = head.status;
                    res_expect_next = '0;
                end
            end
            BK_READ:
            begin
                rd_en     = 1'b1;
                addr_next = rd_addr;
            end
            BK_CMP:
            begin
                idx_next = idx_reg + 1'b1;
                if (hit)
                begin
                    // known sender: store this sequence, compare with last + 1
                    seq_we          = 1'b1;
                    res_expect_next = expect_w;
                    res_status_next = (expect_w == job_reg.seq) ? ST_IN_ORDER : ST_GAP;
                end
                else
                begin
                    if (!free_found_reg && !valid_reg[addr_reg])
                    begin
                        free_found_next = 1'b1;
                        free_addr_next  = addr_reg;
                    end
                    if (last_entry)
                    begin
                        if (free_now)
                        begin
                            wr_addr             = free_found_reg ? free_addr_reg : addr_reg;
                            tag_we              = 1'b1;
                            seq_we              = 1'b1;
                            valid_next[wr_addr] = 1'b1;
                            res_status_next     = ST_FIRST;
                        end
                        else
                            res_status_next = ST_FULL;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res_valid  = (state_reg == BK_OUT);
    assign out_sender = (res_status_reg >= ST_FIRST) ? job_reg.sender : 64'd0;
    assign out_seq    = (res_status_reg >= ST_FIRST) ? job_reg.seq : 64'd0;
    assign res_data   = {2'b00, res_expect_reg, out_seq, out_sender,
                         job_reg.stream, res_status_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg        <= job_next;
        idx_reg        <= idx_next;
        addr_reg       <= addr_next;
        free_found_reg <= free_found_next;
        free_addr_reg  <= free_addr_next;
        res_status_reg <= res_status_next;
        res_expect_reg <= res_expect_next;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            tag_q  <= tag_mem[rd_addr];
            last_q <= seq_mem[rd_addr];
        end
        if (tag_we)
            tag_mem[wr_addr] <= job_reg.sender;
        if (seq_we)
            seq_mem[wr_addr] <= job_reg.seq;
    end

`ifndef SYNTH
    a_plain_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_OUT && !job_reg.lookup) |-> (res_status_reg < ST_FIRST))
        else $error("table status on a frame that needed no lookup");

    a_valid_grows: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) >= $countones($past(valid_reg)))
        else $error("sender entry lost its valid bit");

    a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_CMP) |-> ($past(state_reg) == BK_READ))
        else $error("compare without a preceding read");
`endif

endmodule

FILE: sv/multicast_sequence_gap_checker.sv
// Top level of the multicast sequence gap checker: configuration registers,
// parser front, job queue and sender table. Depends on msgc_pkg and submodules.
//
//  channel   | direction | handshake             | contents
//  s_axis    | in        | tvalid/tready         | one frame byte per word, tlast ends frame
//  m_axis    | out       | tvalid/tready         | one verdict word per frame
//  cfg       | in        | cfg_wr_en, no wait    | stream match and layout registers
//
// The front takes one byte per cycle and only stalls s_axis when the job queue
// (four frames deep) is full. Each frame's verdict passes the table's idle and
// output states, plus a read and a compare state per sender entry scanned when a
// lookup is needed, at most SENDERS_PER_STREAM entries. Reset clears the valid
// bits at once; there is no clearing pass. A stalled m_axis holds the result
// register while the front keeps taking bytes until the job queue is full.
module multicast_sequence_gap_checker
    import msgc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] frame_byte
    input  logic                 s_axis_tlast,
    input  logic                 s_axis_tuser,   // [0] length_mismatch
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [3:0] status, [5:4] stream_index, [69:6] sender_id,
    // [133:70] seq_number, [197:134] expected_seq, [199:198] zero
    output logic [199:0]         m_axis_tdata,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MATCH_W-1:0]   cfg_data
);

    logic [NUM_STREAMS-1:0][MATCH_W-1:0]  match_reg;
    logic [NUM_STREAMS-1:0][LAYOUT_W-1:0] layout_reg;

    logic take_word;
    logic push, pop, q_full, q_empty;
    job_t push_job, head;

    // Hold configuration: even index is a stream's match word, odd its layout.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg  <= '0;
            layout_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            for (int s = 0; s < NUM_STREAMS; s++)
            begin
                if (cfg_index == CFG_IDX_W'(2 * s))
                    match_reg[s] <= cfg_data;
                if (cfg_index == CFG_IDX_W'(2 * s + 1))
                    layout_reg[s] <= cfg_data[LAYOUT_W-1:0];
            end
        end
    end

    // Accept a word whenever the queue has room for a verdict.
    assign s_axis_tready = !q_full;
    assign take_word     = s_axis_tvalid && s_axis_tready;

    msgc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .take_word   (take_word),
        .in_byte     (s_axis_tdata),
        .in_last     (s_axis_tlast),
        .in_mismatch (s_axis_tuser),
        .match_cfg   (match_reg),
        .layout_cfg  (layout_reg),
        .push        (push),
        .job         (push_job)
    );

    msgc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    msgc_table u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head      (head),
        .pop       (pop),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res_data  (m_axis_tdata)
    );

endmodule
